### rtl/psas_pkg.sv
// Package for the phase-space advection scatter block.
// Holds field widths, register codes, reset values and the controller/datapath structs.
// No dependencies.
package psas_pkg;

	localparam int IDX_W   = 4;
	localparam int MASS_W  = 24;
	localparam int ACC_W   = 24;
	localparam int A2V_W   = 24;
	localparam int ORG_W   = 25;
	localparam int STEP_W  = 24;
	localparam int CELL_W  = 32;
	localparam int LOST_W  = 48;
	localparam int FRAC_W  = 16;
	localparam int APB_DW  = 32;
	localparam int APB_AW  = 4;
	localparam int REG_IW  = APB_AW - 2;

	localparam int POS_CELLS_DEF = 16;
	localparam int VEL_CELLS_DEF = 16;

	localparam logic [REG_IW-1:0] REG_A2V  = 2'd0;
	localparam logic [REG_IW-1:0] REG_ORG  = 2'd1;
	localparam logic [REG_IW-1:0] REG_STEP = 2'd2;

	localparam logic OP_SCATTER = 1'b0;
	localparam logic OP_DRAIN   = 1'b1;

	localparam logic [A2V_W-1:0]         A2V_RST  = 24'd209715;
	localparam logic signed [ORG_W-1:0]  ORG_RST  = -25'sd209715;
	localparam logic [STEP_W-1:0]        STEP_RST = 24'd26214;

	typedef struct packed {
		logic load;
		logic mul_vel;
		logic calc_vel;
		logic mul_pos;
		logic pos_add;
		logic mod_step;
		logic mem_rd;
		logic mem_wr;
		logic lost_upd;
		logic clear;
	} psas_cmd_t;

	typedef struct packed {
		logic op_drain;
		logic lost;
		logic mod_last;
		logic clear_last;
	} psas_sts_t;

endpackage

### rtl/psas_regs.sv
// Configuration register file on an APB-style port.
// Holds the velocity factor, velocity origin and velocity step; uses psas_pkg.
module psas_regs
	import psas_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     psel,
	input  logic                     penable,
	input  logic                     pwrite,
	input  logic [APB_AW-1:0]        paddr,
	input  logic [APB_DW-1:0]        pwdata,
	output logic [APB_DW-1:0]        prdata,
	output logic                     pready,
	output logic [A2V_W-1:0]         accel_to_vel_cells,
	output logic signed [ORG_W-1:0]  vel_origin_cells,
	output logic [STEP_W-1:0]        vel_step_cells
);

	logic [A2V_W-1:0]        a2v_q;
	logic signed [ORG_W-1:0] org_q;
	logic [STEP_W-1:0]       step_q;
	logic [REG_IW-1:0]       reg_idx;
	logic                    wr_en;

	assign reg_idx = paddr[APB_AW-1:2];
	assign wr_en   = psel & penable & pwrite;
	assign pready  = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			a2v_q  <= A2V_RST;
			org_q  <= ORG_RST;
			step_q <= STEP_RST;
		end else if (wr_en) begin
			case (reg_idx)
				REG_A2V: begin
					a2v_q <= pwdata[A2V_W-1:0];
				end
				REG_ORG: begin
					org_q <= $signed(pwdata[ORG_W-1:0]);
				end
				REG_STEP: begin
					step_q <= pwdata[STEP_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_A2V: begin
				prdata = APB_DW'(a2v_q);
			end
			REG_ORG: begin
				prdata = APB_DW'(org_q);
			end
			REG_STEP: begin
				prdata = APB_DW'(step_q);
			end
			default: begin
				prdata = '0;
			end
		endcase
	end

	assign accel_to_vel_cells = a2v_q;
	assign vel_origin_cells   = org_q;
	assign vel_step_cells     = step_q;

endmodule

### rtl/psas_ctrl.sv
// Controller state machine for the advection scatter block.
// Sequences the datapath by command struct and reads its status; uses psas_pkg.
module psas_ctrl
	import psas_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      start,
	input  psas_sts_t sts,
	output psas_cmd_t cmd,
	output logic      busy
);

	typedef enum logic [9:0] {
		ST_IDLE  = 10'b0000000001,
		ST_CLEAR = 10'b0000000010,
		ST_MULV  = 10'b0000000100,
		ST_VEL   = 10'b0000001000,
		ST_CHK   = 10'b0000010000,
		ST_PADD  = 10'b0000100000,
		ST_MOD   = 10'b0001000000,
		ST_RD    = 10'b0010000000,
		ST_WR    = 10'b0100000000,
		ST_LOST  = 10'b1000000000
	} state_t;

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			ST_CLEAR: begin
				cmd.clear = 1'b1;
				if (sts.clear_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					state_d  = ST_MULV;
				end
			end
			ST_MULV: begin
				cmd.mul_vel = 1'b1;
				state_d     = sts.op_drain ? ST_RD : ST_VEL;
			end
			ST_VEL: begin
				cmd.calc_vel = 1'b1;
				state_d      = ST_CHK;
			end
			ST_CHK: begin
				if (sts.lost) begin
					state_d = ST_LOST;
				end else begin
					cmd.mul_pos = 1'b1;
					state_d     = ST_PADD;
				end
			end
			ST_PADD: begin
				cmd.pos_add = 1'b1;
				state_d     = ST_MOD;
			end
			ST_MOD: begin
				cmd.mod_step = 1'b1;
				if (sts.mod_last) begin
					state_d = ST_RD;
				end
			end
			ST_RD: begin
				cmd.mem_rd = 1'b1;
				state_d    = ST_WR;
			end
			ST_WR: begin
				cmd.mem_wr = 1'b1;
				state_d    = ST_IDLE;
			end
			ST_LOST: begin
				cmd.lost_upd = 1'b1;
				state_d      = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign busy = (state_q != ST_IDLE);

endmodule

### rtl/psas_dp.sv
// Datapath of the advection scatter block: shift arithmetic, reciprocal-multiply wrap,
// cell store with its clearing counter, lost-mass total and result registers; uses psas_pkg.
module psas_dp
	import psas_pkg::*;
#(
	parameter int POS_CELLS = POS_CELLS_DEF,
	parameter int VEL_CELLS = VEL_CELLS_DEF
)(
	input  logic                     clk,
	input  logic                     arst_n,
	input  psas_cmd_t                cmd,
	output psas_sts_t                sts,
	input  logic                     opcode,
	input  logic [IDX_W-1:0]         pos_x,
	input  logic [IDX_W-1:0]         pos_y,
	input  logic [IDX_W-1:0]         vel_x,
	input  logic [IDX_W-1:0]         vel_y,
	input  logic [MASS_W-1:0]        mass,
	input  logic signed [ACC_W-1:0]  accel_x,
	input  logic signed [ACC_W-1:0]  accel_y,
	input  logic [A2V_W-1:0]         accel_to_vel_cells,
	input  logic signed [ORG_W-1:0]  vel_origin_cells,
	input  logic [STEP_W-1:0]        vel_step_cells,
	output logic                     done,
	output logic [IDX_W-1:0]         dest_pos_x,
	output logic [IDX_W-1:0]         dest_pos_y,
	output logic [IDX_W-1:0]         dest_vel_x,
	output logic [IDX_W-1:0]         dest_vel_y,
	output logic                     lost,
	output logic [CELL_W-1:0]        drained_mass,
	output logic [LOST_W-1:0]        lost_total
);

	localparam int PW     = $clog2(POS_CELLS);
	localparam int VW     = $clog2(VEL_CELLS);
	localparam int AW     = 2 * PW + 2 * VW;
	localparam int DEPTH  = 2 ** AW;
	localparam int PR_W   = ACC_W + A2V_W + 1;
	localparam int VSH    = 32;
	localparam int VS_W   = PR_W - VSH + 1;
	localparam int NV_W   = VS_W + 1;
	localparam int PP_W   = STEP_W + VW;
	localparam int PS_W   = PP_W + 2;
	localparam int SH_W   = PS_W - FRAC_W + 1;
	localparam int PV_W   = SH_W + 1;
	localparam int RW     = PW + 1;
	localparam int RS_W   = PV_W + PW;
	localparam int RCP_W  = PV_W + 1;
	localparam int QP_W   = PV_W + RCP_W;
	localparam int QW     = QP_W - RS_W;
	localparam int RM_W   = QW + RW;
	localparam int CMP_W  = 10;
	localparam longint RCP_V = ((longint'(1) << RS_W) + longint'(POS_CELLS) - 1) /
			longint'(POS_CELLS);
	localparam logic signed [NV_W-1:0] VEL_LIM = NV_W'(VEL_CELLS);
	localparam logic [RW-1:0]          POS_LIM = RW'(POS_CELLS);
	localparam logic [RCP_W-1:0]       RCP     = RCP_W'(RCP_V);

	logic                     op_q;
	logic [IDX_W-1:0]         pin_q [2];
	logic [IDX_W-1:0]         vin_q [2];
	logic signed [ACC_W-1:0]  ain_q [2];
	logic [MASS_W-1:0]        mass_q;
	logic signed [PR_W-1:0]   vprod_q [2];
	logic signed [NV_W-1:0]   nv_q [2];
	logic [PP_W-1:0]          pprod_q [2];
	logic [PV_W-1:0]          mag_q [2];
	logic                     neg_q [2];
	logic [QW-1:0]            quo_q [2];
	logic [RW-1:0]            r_q [2];
	logic                     mph_q;
	logic [CELL_W-1:0]        rdata_q;
	logic [AW-1:0]            clr_q;
	logic [LOST_W-1:0]        total_q;
	logic                     done_q;
	logic [IDX_W-1:0]         opx_q, opy_q, ovx_q, ovy_q;
	logic                     olost_q;
	logic [CELL_W-1:0]        odrain_q;
	logic [CELL_W-1:0]        mem [DEPTH];

	logic signed [NV_W-1:0]   nv_d [2];
	logic signed [PV_W-1:0]   pv_d [2];
	logic [QW-1:0]            quo_d [2];
	logic [RW-1:0]            rem_d [2];
	logic [PW-1:0]            dpos [2];
	logic                     lane_lost [2];
	logic [PW-1:0]            a_px, a_py;
	logic [VW-1:0]            a_vx, a_vy;
	logic [AW-1:0]            addr;
	logic                     drain_ok;
	logic                     mem_we;
	logic [CELL_W-1:0]        wdata;
	logic [CELL_W:0]          csum;
	logic [LOST_W:0]          lsum;

	always_comb begin
		logic [PR_W-1:0]        vmag;
		logic [VS_W-2:0]        vq;
		logic signed [VS_W-1:0] vsh;
		logic signed [PS_W-1:0] psum;
		logic [PS_W-1:0]        pmag;
		logic [SH_W-2:0]        pq;
		logic signed [SH_W-1:0] psh;
		logic [QP_W-1:0]        qprod;
		logic [RM_W-1:0]        rem;
		logic [RW-1:0]          rfix;
		for (int i = 0; i < 2; i++) begin
			vmag = vprod_q[i][PR_W-1] ? PR_W'(-vprod_q[i]) : PR_W'(vprod_q[i]);
			vq   = vmag[PR_W-1:VSH];
			vsh  = vprod_q[i][PR_W-1] ? -$signed({1'b0, vq}) : $signed({1'b0, vq});
			nv_d[i] = $signed({{(NV_W-IDX_W){1'b0}}, vin_q[i]}) + NV_W'(vsh);
			lane_lost[i] = nv_q[i][NV_W-1] || (nv_q[i] >= VEL_LIM);

			psum = PS_W'(vel_origin_cells) + $signed({2'b00, pprod_q[i]});
			pmag = psum[PS_W-1] ? PS_W'(-psum) : PS_W'(psum);
			pq   = pmag[PS_W-1:FRAC_W];
			psh  = psum[PS_W-1] ? -$signed({1'b0, pq}) : $signed({1'b0, pq});
			pv_d[i] = PV_W'(psh) + $signed({{(PV_W-IDX_W){1'b0}}, pin_q[i]});

			qprod    = QP_W'(mag_q[i]) * QP_W'(RCP);
			quo_d[i] = qprod[QP_W-1:RS_W];
			rem      = RM_W'(mag_q[i]) - RM_W'(quo_q[i]) * RM_W'(POS_LIM);
			rem_d[i] = rem[RW-1:0];
			rfix = (neg_q[i] && (r_q[i] != '0)) ? (POS_LIM - r_q[i]) : r_q[i];
			dpos[i] = rfix[PW-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q     <= opcode;
			pin_q[0] <= pos_x;
			pin_q[1] <= pos_y;
			vin_q[0] <= vel_x;
			vin_q[1] <= vel_y;
			ain_q[0] <= accel_x;
			ain_q[1] <= accel_y;
			mass_q   <= mass;
		end
		for (int i = 0; i < 2; i++) begin
			if (cmd.mul_vel) begin
				vprod_q[i] <= PR_W'(ain_q[i]) * PR_W'($signed({1'b0, accel_to_vel_cells}));
			end
			if (cmd.calc_vel) begin
				nv_q[i] <= nv_d[i];
			end
			if (cmd.mul_pos) begin
				pprod_q[i] <= PP_W'(vel_step_cells) * PP_W'(nv_q[i][VW-1:0]);
			end
			if (cmd.pos_add) begin
				neg_q[i] <= pv_d[i][PV_W-1];
				mag_q[i] <= pv_d[i][PV_W-1] ? PV_W'(-pv_d[i]) : PV_W'(pv_d[i]);
			end else if (cmd.mod_step) begin
				if (!mph_q) begin
					quo_q[i] <= quo_d[i];
				end else begin
					r_q[i] <= rem_d[i];
				end
			end
		end
		if (cmd.pos_add) begin
			mph_q <= 1'b0;
		end else if (cmd.mod_step) begin
			mph_q <= 1'b1;
		end
	end

	assign drain_ok = (CMP_W'(pin_q[0]) < CMP_W'(POS_CELLS)) &&
			(CMP_W'(pin_q[1]) < CMP_W'(POS_CELLS)) &&
			(CMP_W'(vin_q[0]) < CMP_W'(VEL_CELLS)) &&
			(CMP_W'(vin_q[1]) < CMP_W'(VEL_CELLS));

	assign a_px = (op_q == OP_DRAIN) ? PW'(pin_q[0]) : dpos[0];
	assign a_py = (op_q == OP_DRAIN) ? PW'(pin_q[1]) : dpos[1];
	assign a_vx = (op_q == OP_DRAIN) ? VW'(vin_q[0]) : nv_q[0][VW-1:0];
	assign a_vy = (op_q == OP_DRAIN) ? VW'(vin_q[1]) : nv_q[1][VW-1:0];
	assign addr = {a_px, a_py, a_vx, a_vy};

	assign csum   = {1'b0, rdata_q} + (CELL_W+1)'(mass_q);
	assign wdata  = (op_q == OP_DRAIN) ? '0 : (csum[CELL_W] ? '1 : csum[CELL_W-1:0]);
	assign mem_we = cmd.mem_wr && ((op_q == OP_SCATTER) || drain_ok);
	assign lsum   = {1'b0, total_q} + (LOST_W+1)'(mass_q);

	always_ff @(posedge clk) begin
		if (cmd.clear) begin
			mem[clr_q] <= '0;
		end else if (mem_we) begin
			mem[addr] <= wdata;
		end
		if (cmd.mem_rd) begin
			rdata_q <= mem[addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q   <= '0;
			total_q <= '0;
			done_q  <= 1'b0;
		end else begin
			if (cmd.clear) begin
				clr_q <= clr_q + 1'b1;
			end
			if (cmd.lost_upd) begin
				total_q <= lsum[LOST_W] ? '1 : lsum[LOST_W-1:0];
			end
			done_q <= cmd.mem_wr | cmd.lost_upd;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.lost_upd) begin
			opx_q    <= '0;
			opy_q    <= '0;
			ovx_q    <= '0;
			ovy_q    <= '0;
			olost_q  <= 1'b1;
			odrain_q <= '0;
		end else if (cmd.mem_wr) begin
			olost_q <= 1'b0;
			if (op_q == OP_DRAIN) begin
				opx_q    <= pin_q[0];
				opy_q    <= pin_q[1];
				ovx_q    <= vin_q[0];
				ovy_q    <= vin_q[1];
				odrain_q <= drain_ok ? rdata_q : '0;
			end else begin
				opx_q    <= IDX_W'(dpos[0]);
				opy_q    <= IDX_W'(dpos[1]);
				ovx_q    <= IDX_W'(nv_q[0][VW-1:0]);
				ovy_q    <= IDX_W'(nv_q[1][VW-1:0]);
				odrain_q <= '0;
			end
		end
	end

	assign sts.op_drain   = (op_q == OP_DRAIN);
	assign sts.lost       = lane_lost[0] | lane_lost[1];
	assign sts.mod_last   = mph_q;
	assign sts.clear_last = (clr_q == '1);

	assign done         = done_q;
	assign dest_pos_x   = opx_q;
	assign dest_pos_y   = opy_q;
	assign dest_vel_x   = ovx_q;
	assign dest_vel_y   = ovy_q;
	assign lost         = olost_q;
	assign drained_mass = odrain_q;
	assign lost_total   = total_q;

endmodule

### rtl/phase_space_advection_scatter.sv
// Top level of the phase-space advection scatter block.
// Instantiates psas_regs, psas_ctrl and psas_dp; uses psas_pkg.
//
// A word is accepted when start is high and busy is low; its result appears on the result ports
// for one cycle with done high, and the receiver cannot hold it off. After reset the block
// clears all 2**(2*clog2(POS_CELLS)+2*clog2(VEL_CELLS)) cells of its store (65536 by default),
// one a cycle, with busy high; registers stay writable. Words go one at a time, each first
// through the velocity multiply. A scatter adds and checks the velocity, then updates the lost
// total or multiplies and adds the position, wraps both positions in the reciprocal-multiply
// unit (quotient, then remainder) and, like a drain, reads and writes its cell; done is high
// in the first cycle with busy low again, and the next word may be accepted at the end of it.
module phase_space_advection_scatter
	import psas_pkg::*;
#(
	parameter int POS_CELLS = POS_CELLS_DEF,
	parameter int VEL_CELLS = VEL_CELLS_DEF
)(
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	output logic                     busy,
	input  logic                     opcode,
	input  logic [IDX_W-1:0]         pos_x,
	input  logic [IDX_W-1:0]         pos_y,
	input  logic [IDX_W-1:0]         vel_x,
	input  logic [IDX_W-1:0]         vel_y,
	input  logic [MASS_W-1:0]        mass,
	input  logic signed [ACC_W-1:0]  accel_x,
	input  logic signed [ACC_W-1:0]  accel_y,
	output logic                     done,
	output logic [IDX_W-1:0]         dest_pos_x,
	output logic [IDX_W-1:0]         dest_pos_y,
	output logic [IDX_W-1:0]         dest_vel_x,
	output logic [IDX_W-1:0]         dest_vel_y,
	output logic                     lost,
	output logic [CELL_W-1:0]        drained_mass,
	output logic [LOST_W-1:0]        lost_total,
	input  logic                     psel,
	input  logic                     penable,
	input  logic                     pwrite,
	input  logic [APB_AW-1:0]        paddr,
	input  logic [APB_DW-1:0]        pwdata,
	output logic [APB_DW-1:0]        prdata,
	output logic                     pready
);

	psas_cmd_t               cmd;
	psas_sts_t               sts;
	logic [A2V_W-1:0]        a2v;
	logic signed [ORG_W-1:0] org;
	logic [STEP_W-1:0]       step;

	psas_regs u_regs (
		.clk                (clk),
		.arst_n             (arst_n),
		.psel               (psel),
		.penable            (penable),
		.pwrite             (pwrite),
		.paddr              (paddr),
		.pwdata             (pwdata),
		.prdata             (prdata),
		.pready             (pready),
		.accel_to_vel_cells (a2v),
		.vel_origin_cells   (org),
		.vel_step_cells     (step)
	);

	psas_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.sts    (sts),
		.cmd    (cmd),
		.busy   (busy)
	);

	psas_dp #(
		.POS_CELLS (POS_CELLS),
		.VEL_CELLS (VEL_CELLS)
	) u_dp (
		.clk                (clk),
		.arst_n             (arst_n),
		.cmd                (cmd),
		.sts                (sts),
		.opcode             (opcode),
		.pos_x              (pos_x),
		.pos_y              (pos_y),
		.vel_x              (vel_x),
		.vel_y              (vel_y),
		.mass               (mass),
		.accel_x            (accel_x),
		.accel_y            (accel_y),
		.accel_to_vel_cells (a2v),
		.vel_origin_cells   (org),
		.vel_step_cells     (step),
		.done               (done),
		.dest_pos_x         (dest_pos_x),
		.dest_pos_y         (dest_pos_y),
		.dest_vel_x         (dest_vel_x),
		.dest_vel_y         (dest_vel_y),
		.lost               (lost),
		.drained_mass       (drained_mass),
		.lost_total         (lost_total)
	);

`ifndef SYNTH
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("busy did not rise after an accepted word");

	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe lasted more than one cycle");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result strobe while a word is still in work");

	a_lost_clean: assert property (@(posedge clk) disable iff (!arst_n)
		done && lost |-> dest_pos_x == '0 && dest_pos_y == '0 && dest_vel_x == '0 &&
		dest_vel_y == '0 && drained_mass == '0)
		else $error("lost result carries nonzero fields");

	a_total_grows: assert property (@(posedge clk) disable iff (!arst_n)
		lost_total >= $past(lost_total))
		else $error("lost-mass total decreased");
`endif

endmodule
